// ----- rtl/core/pqir_pkg.sv -----
package pqir_pkg;

  localparam int PRI_W = 8;
  localparam int ID_W  = 16;
  localparam int HDL_W = 16;
  localparam int OCC_W = 5;
  localparam int CMD_W = 2;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // One queue slot.
  typedef struct packed {
    logic             valid;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
    logic [HDL_W-1:0] hdl;
  } entry_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic             en;
    logic             push;
    logic             pop;
    logic             remove;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
    logic [HDL_W-1:0] hdl;
  } cell_ctl_t;

endpackage

// ----- rtl/core/priority_queue_with_id_removal.sv -----
// Stable priority queue with removal by message id.
// Input channel (s_axis): tuser carries the command (push, pop head, remove by
// id); tdata carries priority, message id and payload handle of a push, or the
// id searched by a remove. Output channel (m_axis): one word per command, with
// the status in tuser and the removed entry plus the occupancy in tdata.
// Entries sit in a row of cells sorted by priority, head in cell 0; a push is
// placed behind all entries of equal or higher priority, so equal priorities
// leave in arrival order. All cells compare against the command at once and
// shift toward or away from the head in the same cycle.
// Latency: the result word is valid the cycle after the command is accepted.
// Throughput: one command per cycle while the output is not stalled; each
// command updates the cell row and its result is held in the output register.
// When the receiver stalls, the output word holds and s_axis_tready drops
// until it is taken; a new command is accepted in the same cycle the pending
// word leaves.
// Reset empties the queue and clears the output valid; no clearing pass.
module priority_queue_with_id_removal #(
  parameter int CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] priority_req, [23:8] message_id, [39:24] payload_handle
  input  logic [39:0] s_axis_tdata_i,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_priority, [23:8] out_message_id, [39:24] out_handle,
  // [44:40] occupancy, [47:45] zero
  output logic [47:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o
);
  import pqir_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_ctl_t   ctl;
  entry_t      ent [CAPACITY];
  entry_t      sel [CAPACITY];
  logic        ins [CAPACITY+1];
  logic        hit [CAPACITY+1];
  entry_t      found;
  logic        accept;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W+OCC_W-1:0] cnt_ext;
  logic [ST_W-1:0] status;

  logic            out_valid_q;
  logic [47:0]     out_data_q, out_data_d;
  logic [ST_W-1:0] out_status_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Drop a push into a full row: leave every cell as it is.
  assign ctl.en     = accept && !(ctl.push && (cnt_q == CNT_W'(CAPACITY)));
  assign ctl.push   = (s_axis_tuser_i == CMD_PUSH);
  assign ctl.pop    = (s_axis_tuser_i == CMD_POP);
  assign ctl.remove = (s_axis_tuser_i == CMD_REMOVE);
  assign ctl.pri    = s_axis_tdata_i[7:0];
  assign ctl.id     = s_axis_tdata_i[23:8];
  assign ctl.hdl    = s_axis_tdata_i[39:24];

  assign ins[0] = 1'b0;
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_body
      assign right_w = ent[i+1];
    end
    pqir_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .left_i     (left_w),
      .right_i    (right_w),
      .ins_left_i (ins[i]),
      .hit_left_i (hit[i]),
      .ent_o      (ent[i]),
      .ins_o      (ins[i+1]),
      .hit_o      (hit[i+1]),
      .sel_o      (sel[i])
    );
  end

  // At most one cell selects, so an OR gathers the removed word.
  always_comb begin
    found = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found = found | sel[i];
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    status = ST_EMPTY;
    if (ctl.push) begin
      if (cnt_q == CNT_W'(CAPACITY)) begin
        status = ST_FULL;
      end else begin
        status = ST_OK;
        cnt_d  = cnt_q + 1'b1;
      end
    end else if ((ctl.pop || ctl.remove) && hit[CAPACITY]) begin
      status = ST_OK;
      cnt_d  = cnt_q - 1'b1;
    end
  end

  assign cnt_ext = {{OCC_W{1'b0}}, cnt_d};

  always_comb begin
    out_data_d = '0;
    if (ctl.pop || ctl.remove) begin
      out_data_d[7:0]   = found.pri;
      out_data_d[23:8]  = found.id;
      out_data_d[39:24] = found.hdl;
    end
    out_data_d[44:40] = cnt_ext[OCC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q   <= out_data_d;
      out_status_q <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

// ----- rtl/core/pqir_cell.sv -----
module pqir_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pqir_pkg::cell_ctl_t ctl_i,
  input  pqir_pkg::entry_t   left_i,
  input  pqir_pkg::entry_t   right_i,
  input  logic               ins_left_i,
  input  logic               hit_left_i,
  output pqir_pkg::entry_t   ent_o,
  output logic               ins_o,
  output logic               hit_o,
  output pqir_pkg::entry_t   sel_o
);
  import pqir_pkg::*;

  logic   valid_q, valid_d;
  entry_t data_q, data_d;
  logic   match;
  logic   first;

  // Insert point: first slot that is free or holds a lower priority.
  assign ins_o = !valid_q || (data_q.pri < ctl_i.pri);
  assign match = valid_q && (ctl_i.pop || (data_q.id == ctl_i.id));
  assign hit_o = hit_left_i | match;
  assign first = match && !hit_left_i;

  assign ent_o = '{valid: valid_q, pri: data_q.pri, id: data_q.id, hdl: data_q.hdl};
  assign sel_o = first ? ent_o : '0;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctl_i.en && ctl_i.push && ins_o) begin
      if (ins_left_i) begin
        // make room: take the word of the left neighbor
        valid_d = left_i.valid;
        data_d  = left_i;
      end else begin
        valid_d = 1'b1;
        data_d  = '{valid: 1'b1, pri: ctl_i.pri, id: ctl_i.id, hdl: ctl_i.hdl};
      end
    end else if (ctl_i.en && (ctl_i.pop || ctl_i.remove) && hit_o) begin
      // close the gap behind the removed slot
      valid_d = right_i.valid;
      data_d  = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ----- rtl/core/pqir_chk.sv -----
module pqir_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [39:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);
  import pqir_pkg::*;

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // Input is only held off by a pending, stalled result.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a pending result");

  // Failed commands return no entry.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_EMPTY || m_axis_tuser_o == ST_FULL)
      |-> m_axis_tdata_o[39:0] == 40'd0)
    else $error("failed command returned entry data");

  // Every accepted command produces a result word on the next cycle.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted command gave no result");

endmodule

bind priority_queue_with_id_removal pqir_chk u_pqir_chk (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import pqir_pkg::*;

  localparam int CAPACITY = 16;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_PER_PHASE = 200;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
    logic [HDL_W-1:0] hdl;
  } slot_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
    logic [HDL_W-1:0] hdl;
    logic [OCC_W-1:0] occ;
  } outcome_t;

  // Mirror of the queue contents; predicts one result word per command.
  class queue_mirror;
    slot_t    held[$];
    outcome_t expected_words[$];
    int       errors;
    int       words_seen;
    int       cmd_count[4];
    int       full_drops;
    int       misses;

    function new();
      errors = 0;
      words_seen = 0;
      full_drops = 0;
      misses = 0;
      foreach (cmd_count[k]) cmd_count[k] = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%0t ERROR: %s", $realtime, msg);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function logic [ID_W-1:0] held_id();
      return held[$urandom_range(held.size() - 1)].id;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [PRI_W-1:0] pri,
                               logic [ID_W-1:0] id, logic [HDL_W-1:0] hdl);
      outcome_t r;
      slot_t    s;
      int       pos;
      int       take;
      r = '0;
      r.status = ST_EMPTY;
      take = -1;
      cmd_count[cmd]++;
      case (cmd)
        CMD_PUSH: begin
          if (held.size() >= CAPACITY) begin
            r.status = ST_FULL;
            full_drops++;
          end else begin
            // place behind every entry of equal or higher priority
            pos = held.size();
            for (int i = 0; i < held.size(); i++) begin
              if (held[i].pri < pri) begin
                pos = i;
                break;
              end
            end
            s.pri = pri;
            s.id = id;
            s.hdl = hdl;
            held.insert(pos, s);
            r.status = ST_OK;
          end
        end
        CMD_POP: begin
          if (held.size() > 0) take = 0;
        end
        CMD_REMOVE: begin
          for (int i = 0; i < held.size(); i++) begin
            if (held[i].id == id) begin
              take = i;
              break;
            end
          end
        end
        default: ;
      endcase
      if (take >= 0) begin
        r.status = ST_OK;
        r.pri = held[take].pri;
        r.id = held[take].id;
        r.hdl = held[take].hdl;
        held.delete(take);
      end else if (cmd != CMD_PUSH) begin
        misses++;
      end
      r.occ = OCC_W'(held.size());
      expected_words.push_back(r);
    endfunction

    function void check_word(logic [47:0] data, logic [ST_W-1:0] user);
      outcome_t want;
      outcome_t got;
      got.status = user;
      got.pri = data[7:0];
      got.id = data[23:8];
      got.hdl = data[39:24];
      got.occ = data[44:40];
      words_seen++;
      if (expected_words.size() == 0) begin
        report($sformatf("result word %0d arrived with no command waiting", words_seen));
        return;
      end
      want = expected_words.pop_front();
      if (got.status !== want.status || got.pri !== want.pri || got.id !== want.id ||
          got.hdl !== want.hdl || got.occ !== want.occ)
        report($sformatf({"word %0d: expected st %0d pri %h id %h hdl %h occ %0d, ",
                          "got st %0d pri %h id %h hdl %h occ %0d"}, words_seen,
                         want.status, want.pri, want.id, want.hdl, want.occ,
                         got.status, got.pri, got.id, got.hdl, got.occ));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_n = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [39:0]       s_tdata = '0;
  logic [CMD_W-1:0]  s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [47:0]       m_tdata;
  logic [ST_W-1:0]   m_tuser;

  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          cycles = 0;
  queue_mirror mirror = new();

  priority_queue_with_id_removal #(.CAPACITY(CAPACITY)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("priority_queue_with_id_removal test failed");
      $finish;
    end
  end

  // Take result words, stalling at random.
  always @(posedge clk_i) begin
    if (rst_n && m_tvalid && m_tready) mirror.check_word(m_tdata, m_tuser);
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [PRI_W-1:0] pri,
                              input logic [ID_W-1:0] id, input logic [HDL_W-1:0] hdl);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {hdl, id, pri};
    do @(posedge clk_i); while (!s_tready);
    mirror.note_command(cmd, pri, id, hdl);
  endtask

  // Hold off the sender until every word has come back.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int push_pct);
    logic [CMD_W-1:0] cmd;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
    logic [HDL_W-1:0] hdl;
    int               roll;
    roll = $urandom_range(99);
    hdl = HDL_W'($urandom);
    // few priority levels give plenty of ties
    if ($urandom_range(3) == 0) pri = PRI_W'($urandom);
    else pri = PRI_W'($urandom_range(0, 3) * 85);
    if ($urandom_range(3) == 0) id = ID_W'($urandom);
    else id = ID_W'($urandom_range(0, 7));
    if (roll < 3) begin
      cmd = CMD_NOP;
    end else if (roll < 3 + push_pct) begin
      cmd = CMD_PUSH;
    end else if ($urandom_range(1) == 0) begin
      cmd = CMD_POP;
    end else begin
      cmd = CMD_REMOVE;
      if (mirror.held.size() > 0 && $urandom_range(3) != 0) id = mirror.held_id();
    end
    send_command(cmd, pri, id, hdl);
  endtask

  initial begin
    int push_pct;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 34;
    sink_idle_pct = 80;
    send_command(CMD_POP, 8'h00, 16'h0000, 16'h0000);
    send_command(CMD_REMOVE, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_command(CMD_NOP, 8'hA5, 16'h5AA5, 16'hC33C);
    send_command(CMD_PUSH, 8'h00, 16'h0000, 16'h0000);
    send_command(CMD_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_command(CMD_PUSH, 8'h80, 16'h1234, 16'hABCD);
    send_command(CMD_PUSH, 8'h80, 16'h1235, 16'h5432);
    send_command(CMD_REMOVE, 8'h00, 16'h1235, 16'h0000);
    send_command(CMD_REMOVE, 8'h00, 16'h7777, 16'h0000);
    send_command(CMD_NOP, 8'h00, 16'h0000, 16'h0000);
    send_command(CMD_POP, 8'h00, 16'h0000, 16'h0000);
    // fill to capacity, then push once more into a full queue
    for (int i = 0; i < CAPACITY - 2; i++)
      send_command(CMD_PUSH, PRI_W'(i * 19), ID_W'(16'h0100 + i), HDL_W'(i * 4681));
    send_command(CMD_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF);
    wait_for_results();

    push_pct = 45;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 34; sink_idle_pct = 80; end
        1: begin src_idle_pct = 80; sink_idle_pct = 34; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // swing between filling, draining and balanced traffic
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: push_pct = 75;
            1: push_pct = 25;
            default: push_pct = 45;
          endcase
        end
        send_random(push_pct);
      end
      wait_for_results();
    end

    repeat (4) @(posedge clk_i);
    if (mirror.pending() != 0)
      mirror.report($sformatf("%0d result words never arrived", mirror.pending()));
    $display("covered %0d commands: %0d push, %0d pop, %0d remove, %0d undefined code",
             mirror.cmd_count[0] + mirror.cmd_count[1] + mirror.cmd_count[2] +
             mirror.cmd_count[3], mirror.cmd_count[0], mirror.cmd_count[1],
             mirror.cmd_count[2], mirror.cmd_count[3]);
    $display("%0d pushes dropped on a full queue, %0d empty or no-match results, %0d errors",
             mirror.full_drops, mirror.misses, mirror.errors);
    if (mirror.errors == 0) begin
      $display("priority_queue_with_id_removal test passed");
    end else begin
      $display("priority_queue_with_id_removal test failed");
    end
    $finish;
  end

endmodule
